@@ rtl/nls_pkg.sv @@
// ----------------------------------------------------------------------------
// nls_pkg
// Shared types and constants for the newline line splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

   // Field widths fixed by the interface.
   localparam int CSR_WIDTH      = 21;
   localparam int BYTE_WIDTH     = 8;
   localparam int LINE_NUM_WIDTH = 32;

   // Transaction kinds on the request channel.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   // Characters with special meaning in the stream.
   localparam logic [BYTE_WIDTH-1:0] CH_LF = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CH_CR = 8'h0D;

   // Result queue geometry.
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_CNT_BITS = 3;

   // One result transaction.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0]     out_byte;
      logic [LINE_NUM_WIDTH-1:0] line_number;
      logic                      last_of_line;
      logic                      overflow_error;
   } result_type;

   // Results produced by one input transaction, oldest first.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

@@ rtl/nls_line_core.sv @@
// ----------------------------------------------------------------------------
// nls_line_core
// Line state, byte holdback and limit register. Turns one input transaction
// into zero, one or two results combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_line_core
   import nls_pkg::*;
#(
   parameter int LINE_LIMIT_MAX   = 1048576,
   parameter int LINE_NUMBER_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_WIDTH-1:0]  csr_wr_data,
   input  wire logic                  item_valid,
   input  wire logic                  item_kind,
   input  wire logic [BYTE_WIDTH-1:0] item_byte,
   input  wire logic                  space_ok,
   output logic                       item_take,
   output push_type                   push
);

   localparam int LIM_BITS = $clog2(LINE_LIMIT_MAX + 1);
   localparam int CMP_BITS = (LIM_BITS > CSR_WIDTH) ? LIM_BITS : CSR_WIDTH;
   localparam logic [CMP_BITS-1:0] LIMIT_CAP = CMP_BITS'(LINE_LIMIT_MAX);

   logic [CMP_BITS-1:0]         max_bytes_ff, max_bytes_in;
   logic [BYTE_WIDTH-1:0]       pend0_ff, pend0_in;
   logic [BYTE_WIDTH-1:0]       pend1_ff, pend1_in;
   logic [1:0]                  pend_cnt_ff, pend_cnt_in;
   logic [LIM_BITS-1:0]         line_len_ff, line_len_in;
   logic [LINE_NUMBER_BITS-1:0] line_num_ff, line_num_in;
   logic                        halted_ff, halted_in;

   logic [LIM_BITS-1:0]         limit;
   logic [LINE_NUM_WIDTH-1:0]   line_num_out;
   logic [1:0]                  flush_cnt;
   logic                        flush_first_last;

   // The limit register is clamped to what the line counter can hold.
   assign limit = (max_bytes_ff > LIMIT_CAP) ? LIM_BITS'(LIMIT_CAP)
                                             : LIM_BITS'(max_bytes_ff);
   assign line_num_out = LINE_NUM_WIDTH'(line_num_ff);
   assign item_take    = item_valid && space_ok;

   // Configuration write.
   assign max_bytes_in = csr_wr_en ? CMP_BITS'(csr_wr_data) : max_bytes_ff;

   // Closing a line: drop one trailing CR from the held bytes.
   always_comb begin
      flush_cnt        = 2'd0;
      flush_first_last = 1'b1;
      case (pend_cnt_ff)
         2'd1: begin
            flush_cnt = (pend0_ff == CH_CR) ? 2'd0 : 2'd1;
         end
         2'd2, 2'd3: begin
            if (pend1_ff == CH_CR) begin
               flush_cnt = 2'd1;
            end else begin
               flush_cnt        = 2'd2;
               flush_first_last = 1'b0;
            end
         end
         default: begin
            flush_cnt = 2'd0;
         end
      endcase
   end

   // Per-transaction state update and result generation.
   always_comb begin
      pend0_in    = pend0_ff;
      pend1_in    = pend1_ff;
      pend_cnt_in = pend_cnt_ff;
      line_len_in = line_len_ff;
      line_num_in = line_num_ff;
      halted_in   = halted_ff;
      push.count  = 2'd0;
      push.first  = '{out_byte: pend0_ff, line_number: line_num_out,
                      last_of_line: flush_first_last, overflow_error: 1'b0};
      push.second = '{out_byte: pend1_ff, line_number: line_num_out,
                      last_of_line: 1'b1, overflow_error: 1'b0};
      if (item_take) begin
         if (item_kind == KIND_EOS) begin
            if (!halted_ff) begin
               push.count = flush_cnt;
            end
            pend_cnt_in = 2'd0;
            line_len_in = '0;
            line_num_in = LINE_NUMBER_BITS'(1);
            halted_in   = 1'b0;
         end else if (!halted_ff) begin
            if (item_byte == CH_LF) begin
               push.count  = flush_cnt;
               pend_cnt_in = 2'd0;
               line_len_in = '0;
               if (!(&line_num_ff)) begin
                  line_num_in = line_num_ff + 1'b1;
               end
            end else if (line_len_ff >= limit) begin
               // Line too long: report once and wait for end of stream.
               push.count  = 2'd1;
               push.first  = '{out_byte: '0, line_number: line_num_out,
                               last_of_line: 1'b0, overflow_error: 1'b1};
               pend_cnt_in = 2'd0;
               line_len_in = '0;
               halted_in   = 1'b1;
            end else begin
               line_len_in = LIM_BITS'(line_len_ff + 1'b1);
               if (pend_cnt_ff[1]) begin
                  // The oldest held byte now has a successor, so it goes out.
                  push.count              = 2'd1;
                  push.first.last_of_line = 1'b0;
                  pend0_in                = pend1_ff;
                  pend1_in                = item_byte;
               end else if (pend_cnt_ff == 2'd0) begin
                  pend0_in    = item_byte;
                  pend_cnt_in = 2'd1;
               end else begin
                  pend1_in    = item_byte;
                  pend_cnt_in = 2'd2;
               end
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= LIMIT_CAP;
         pend_cnt_ff  <= 2'd0;
         line_len_ff  <= '0;
         line_num_ff  <= LINE_NUMBER_BITS'(1);
         halted_ff    <= 1'b0;
      end else begin
         max_bytes_ff <= max_bytes_in;
         pend_cnt_ff  <= pend_cnt_in;
         line_len_ff  <= line_len_in;
         line_num_ff  <= line_num_in;
         halted_ff    <= halted_in;
      end
   end

   // Held bytes carry no reset; only entries below the count are used.
   always_ff @(posedge clock) begin
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

endmodule

`default_nettype wire

@@ rtl/nls_result_fifo.sv @@
// ----------------------------------------------------------------------------
// nls_result_fifo
// Small result queue that takes up to two results per cycle and hands out
// one per cycle on the response channel while rsp_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_result_fifo
   import nls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   output logic            space_ok,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      head
);

   result_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]   count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_next;
   logic                       pop;

   // Status and head of queue.
   assign rsp_valid   = (count_ff != '0);
   assign head        = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign space_ok    = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // Pointer and occupancy update.
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
   assign count_in  = count_ff + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage; the older result lands first.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

@@ rtl/newline_line_splitter.sv @@
// ----------------------------------------------------------------------------
// newline_line_splitter
// Splits a byte stream into lines at LF and tags each byte with its line.
// ----------------------------------------------------------------------------
// The block takes one request transaction per cycle while the queue has room.
// A request is held in the input register until the line logic processes it,
// and its results (none, one or two) enter a four-entry result queue. The
// request side stalls only when the result queue holds more than two entries;
// since the response channel drains one result per cycle while rsp_ready is
// high, the sustained rate is one request per cycle unless line ends that
// release two held bytes outpace the response side. After reset the block is
// ready at once; no clearing pass is needed.
`default_nettype none

module newline_line_splitter
   import nls_pkg::*;
#(
   parameter int LINE_LIMIT_MAX   = 1048576,
   parameter int LINE_NUMBER_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_WIDTH-1:0]      csr_wr_data,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_kind,
   input  wire logic [BYTE_WIDTH-1:0]     req_in_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [BYTE_WIDTH-1:0]          rsp_out_byte,
   output logic [LINE_NUM_WIDTH-1:0]      rsp_line_number,
   output logic                           rsp_last_of_line,
   output logic                           rsp_overflow_error
);

   logic                  in_valid_ff, in_valid_in;
   logic                  in_kind_ff, in_kind_in;
   logic [BYTE_WIDTH-1:0] in_byte_ff, in_byte_in;
   logic                  item_take;
   logic                  space_ok;
   logic                  req_accept;
   push_type              push;
   result_type            head;

   // Input register: refilled in the same cycle its transaction is consumed.
   assign req_ready   = !in_valid_ff || item_take;
   assign req_accept  = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !item_take);
   assign in_kind_in  = req_accept ? req_kind    : in_kind_ff;
   assign in_byte_in  = req_accept ? req_in_byte : in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff <= in_kind_in;
      in_byte_ff <= in_byte_in;
   end

   nls_line_core #(
      .LINE_LIMIT_MAX   (LINE_LIMIT_MAX),
      .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (in_valid_ff),
      .item_kind   (in_kind_ff),
      .item_byte   (in_byte_ff),
      .space_ok    (space_ok),
      .item_take   (item_take),
      .push        (push)
   );

   nls_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   // Response payload.
   assign rsp_out_byte       = head.out_byte;
   assign rsp_line_number    = head.line_number;
   assign rsp_last_of_line   = head.last_of_line;
   assign rsp_overflow_error = head.overflow_error;

endmodule

`default_nettype wire

@@ rtl/nls_checker.sv @@
// ----------------------------------------------------------------------------
// nls_checker
// Port-level checks for the newline line splitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_checker
   import nls_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [BYTE_WIDTH-1:0]     rsp_out_byte,
   input wire logic [LINE_NUM_WIDTH-1:0] rsp_line_number,
   input wire logic                      rsp_last_of_line,
   input wire logic                      rsp_overflow_error
);

   // After reset the block is empty and ready for a transaction.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty and ready after reset");

   // A stalled response transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_line_number) && $stable(rsp_last_of_line)
         && $stable(rsp_overflow_error)))
      else $error("stalled response changed");

   // An overflow report carries no byte and no end-of-line mark.
   a_ovf_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow_error) |-> (!rsp_last_of_line && rsp_out_byte == '0))
      else $error("overflow response with byte fields set");

   // Line numbers count from one.
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0))
      else $error("response with line number zero");

endmodule

bind newline_line_splitter nls_checker u_nls_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_line_number    (rsp_line_number),
   .rsp_last_of_line   (rsp_last_of_line),
   .rsp_overflow_error (rsp_overflow_error)
);

`default_nettype wire
